### rtl/dht_pkg.sv
`timescale 1ns / 1ps
package dht_pkg;

	// operation codes
	typedef enum logic [1:0] {
		OP_FIND  = 2'd0,
		OP_ENTER = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// status codes
	typedef enum logic [2:0] {
		ST_FOUND     = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_CLEARED   = 3'd4
	} status_t;

	localparam int unsigned SIZE_W    = 10;
	localparam int unsigned SIZE_MIN  = 5;
	localparam int unsigned SIZE_RST  = 1021;
	localparam int unsigned HASH_W    = 32;
	localparam int unsigned KEY_W     = 64;
	localparam int unsigned LEN_W     = 4;
	localparam int unsigned VAL_W     = 32;

endpackage

### rtl/dht_ram.sv
`timescale 1ns / 1ps
module dht_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/dht_modu.sv
`timescale 1ns / 1ps
// restoring remainder a % m, one quotient bit per cycle
module dht_modu #(
	parameter int unsigned DW = 32,
	parameter int unsigned MW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [DW-1:0] dividend,
	input  logic [MW-1:0] modulus,
	output logic          done,
	output logic [MW-1:0] rem
);
	localparam int unsigned CW = $clog2(DW + 1);

	logic [DW-1:0] num_q;
	logic [MW:0]   rem_q;
	logic [MW-1:0] mod_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [MW:0]   trial;

	assign trial = {rem_q[MW-1:0], num_q[DW-1]};

	// shift in one dividend bit, subtract when it fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= dividend;
			rem_q <= '0;
			mod_q <= modulus;
		end else if (run_q) begin
			num_q <= {num_q[DW-2:0], 1'b0};
			if (trial >= {1'b0, mod_q}) begin
				rem_q <= trial - {1'b0, mod_q};
			end else begin
				rem_q <= trial;
			end
		end
	end

	assign rem = rem_q[MW-1:0];
endmodule

### rtl/double_hash_table_engine.sv
`timescale 1ns / 1ps
// channel | direction | beat marker        | payload
// cfg     | in        | table_size_we      | table_size_wdata
// command | in        | start & !busy      | op, key_bytes, key_len, value_in
// result  | out       | done (one cycle)   | status, value_out
//
// an item is hashed one key byte at a time, then the two remainders are taken in
// turn in the shared serial modulo unit; the first probe is a tag ram read, wait and
// compare, each further one a step, read, wait and compare; an insert adds a write
// state, and a reply state ends the item. clear writes one slot per cycle over all
// TABLE_DEPTH slots and then replies; after reset a clearing pass over all
// TABLE_DEPTH slots keeps busy high.
// results cannot be held off by the receiver.
module double_hash_table_engine #(
	parameter int unsigned TABLE_DEPTH   = 1024,
	parameter int unsigned MAX_KEY_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          table_size_we,
	input  logic [dht_pkg::SIZE_W-1:0]    table_size_wdata,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    op,
	input  logic [dht_pkg::KEY_W-1:0]     key_bytes,
	input  logic [dht_pkg::LEN_W-1:0]     key_len,
	input  logic signed [dht_pkg::VAL_W-1:0] value_in,
	output logic                          done,
	output logic [2:0]                    status,
	output logic signed [dht_pkg::VAL_W-1:0] value_out
);
	import dht_pkg::*;

	localparam int unsigned AW     = $clog2(TABLE_DEPTH);
	localparam int unsigned SW     = AW + 1;
	localparam int unsigned SZ_MAX = TABLE_DEPTH - 3;
	localparam int unsigned CW     = AW + 1;
	localparam int unsigned ENT_W  = KEY_W + LEN_W + VAL_W;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_CLR   = 12'b000000000010,
		S_HASH  = 12'b000000000100,
		S_MOD1  = 12'b000000001000,
		S_MOD2  = 12'b000000010000,
		S_RD    = 12'b000000100000,
		S_WAIT  = 12'b000001000000,
		S_CMP   = 12'b000010000000,
		S_STEP  = 12'b000100000000,
		S_WR    = 12'b001000000000,
		S_RESP  = 12'b010000000000,
		S_VAL   = 12'b100000000000
	} state_t;

	state_t        state_q;
	logic [SIZE_W-1:0] size_q;
	logic [SW-1:0] sz_q;
	logic [1:0]    op_q;
	logic [KEY_W-1:0] key_q;
	logic [LEN_W-1:0] len_q;
	logic [VAL_W-1:0] vin_q;
	logic [HASH_W-1:0] hash_q;
	logic [LEN_W-1:0] bcnt_q;
	logic [AW-1:0] h_q, idx_q, step_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] clr_q;
	logic          clr_reply_q;
	logic          probed_q;
	logic [2:0]    st_q;

	// effective size
	logic [SW-1:0] sz_eff;
	always_comb begin
		sz_eff = SW'(size_q);
		if (32'(size_q) < SIZE_MIN) sz_eff = SW'(SIZE_MIN);
		if (32'(size_q) > SZ_MAX) sz_eff = SW'(SZ_MAX);
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(SIZE_RST);
		end else if (table_size_we) begin
			size_q <= table_size_wdata;
		end
	end

	// shared modulo unit
	logic          mod_go, mod_done;
	logic [HASH_W-1:0] mod_a;
	logic [SW-1:0] mod_m, mod_r;
	dht_modu #(.DW(HASH_W), .MW(SW)) u_mod (
		.clk(clk), .arst_n(arst_n), .go(mod_go), .dividend(mod_a),
		.modulus(mod_m), .done(mod_done), .rem(mod_r)
	);

	// home slot straight from the first remainder, zero maps to one
	logic [AW-1:0] h_new;
	assign h_new = (mod_r == '0) ? AW'(1) : mod_r[AW-1:0];

	// tag and entry memories
	logic          tag_we, ent_we;
	logic [AW-1:0] tag_wa;
	logic [SIZE_W-1:0] tag_wd, tag_rd;
	logic [ENT_W-1:0] ent_rd;
	dht_ram #(.WIDTH(SIZE_W), .DEPTH(TABLE_DEPTH)) u_tag (
		.clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd),
		.raddr(idx_q), .rdata(tag_rd)
	);
	dht_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_ent (
		.clk(clk), .we(ent_we), .waddr(idx_q), .wdata({key_q, len_q, vin_q}),
		.raddr(idx_q), .rdata(ent_rd)
	);

	assign tag_we = (state_q == S_CLR) || (state_q == S_WR);
	assign tag_wa = (state_q == S_CLR) ? clr_q : idx_q;
	assign tag_wd = (state_q == S_CLR) ? '0 : SIZE_W'(h_q);
	assign ent_we = (state_q == S_WR);

	assign mod_go = (state_q == S_HASH && bcnt_q == '0) ||
		(state_q == S_MOD1 && mod_done);
	assign mod_a  = (state_q == S_HASH) ? hash_q : HASH_W'(h_new);
	assign mod_m  = (state_q == S_HASH) ? sz_q : sz_q - SW'(2);

	logic match, empty;
	assign empty = (tag_rd == '0);
	assign match = (tag_rd == SIZE_W'(h_q)) && (ent_rd[VAL_W +: LEN_W] == len_q)
		&& (ent_rd[VAL_W+LEN_W +: KEY_W] == key_q);

	// key masking
	logic [LEN_W-1:0] len_c;
	logic [KEY_W-1:0] key_c;
	always_comb begin
		len_c = (key_len > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES) : key_len;
		for (int i = 0; i < 8; i++) begin
			key_c[8*i +: 8] = (LEN_W'(i) < len_c) ? key_bytes[8*i +: 8] : 8'd0;
		end
	end

	logic [7:0] cur_byte;
	assign cur_byte = key_q[{bcnt_q[2:0] - 3'd1, 3'b000} +: 8];

	logic [SW-1:0] idx_next;
	assign idx_next = ({1'b0, idx_q} <= {1'b0, step_q}) ?
		sz_q + {1'b0, idx_q} - {1'b0, step_q} : {1'b0, idx_q} - {1'b0, step_q};

	assign busy = (state_q != S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			clr_reply_q <= 1'b0;
			count_q     <= '0;
			done        <= 1'b0;
			st_q        <= ST_NOT_FOUND;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (op)
							OP_CLEAR: begin
								state_q     <= S_CLR;
								clr_q       <= '0;
								clr_reply_q <= 1'b1;
							end
							OP_NONE: begin
								st_q    <= ST_NOT_FOUND;
								state_q <= S_RESP;
							end
							default: state_q <= S_HASH;
						endcase
					end
				end
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(TABLE_DEPTH - 1)) begin
						count_q <= '0;
						st_q    <= ST_CLEARED;
						state_q <= clr_reply_q ? S_RESP : S_IDLE;
					end
				end
				S_HASH: if (bcnt_q == '0) state_q <= S_MOD1;
				S_MOD1: if (mod_done) state_q <= S_MOD2;
				S_MOD2: if (mod_done) state_q <= S_RD;
				S_RD:   state_q <= S_WAIT;
				S_WAIT: state_q <= S_CMP;
				S_CMP: begin
					if (probed_q && idx_q == h_q) begin
						st_q    <= (op_q == OP_ENTER) ? ST_FULL : ST_NOT_FOUND;
						state_q <= S_RESP;
					end else if (!empty && match) begin
						st_q    <= ST_FOUND;
						state_q <= S_VAL;
					end else if (empty) begin
						if (op_q != OP_ENTER) begin
							st_q    <= ST_NOT_FOUND;
							state_q <= S_RESP;
						end else if (SW'(count_q) >= sz_q) begin
							st_q    <= ST_FULL;
							state_q <= S_RESP;
						end else begin
							st_q    <= ST_INSERTED;
							state_q <= S_WR;
						end
					end else begin
						state_q <= S_STEP;
					end
				end
				S_STEP: state_q <= S_RD;
				S_WR: begin
					count_q <= count_q + 1'b1;
					state_q <= S_VAL;
				end
				S_VAL, S_RESP: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q     <= start ? op : OP_CLEAR;
				key_q    <= key_c;
				len_q    <= len_c;
				bcnt_q   <= len_c;
				vin_q    <= value_in;
				hash_q   <= HASH_W'(len_c);
				sz_q     <= sz_eff;
				probed_q <= 1'b0;
			end
			S_HASH: if (bcnt_q != '0) begin
				hash_q <= {hash_q[HASH_W-5:0], 4'd0} + HASH_W'(cur_byte);
				bcnt_q <= bcnt_q - 1'b1;
			end
			S_MOD1: if (mod_done) begin
				h_q   <= h_new;
				idx_q <= h_new;
			end
			S_MOD2: if (mod_done) step_q <= mod_r[AW-1:0] + 1'b1;
			S_STEP: begin
				idx_q    <= idx_next[AW-1:0];
				probed_q <= 1'b1;
			end
			default: ;
		endcase
		if (state_q == S_RESP) begin
			status    <= st_q;
			value_out <= '0;
		end else if (state_q == S_VAL) begin
			status    <= st_q;
			value_out <= (st_q == ST_INSERTED) ? vin_q : ent_rd[VAL_W-1:0];
		end
	end

`ifndef SYNTH
	// the entry count never passes the table size limit
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SZ_MAX)) else $error("entry count overflow");
	// a result beat only follows the reply states
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_RESP || $past(state_q) == S_VAL))
		else $error("stray result beat");
	// probe index stays within the table
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (idx_q != '0 && SW'(idx_q) <= sz_q))
		else $error("probe index out of range");
`endif
endmodule

### sim/tb_double_hash_table_engine.sv
`timescale 1ns / 1ps

// predicts the table contents and holds the expected result beats
class hash_table_scoreboard;
	typedef struct {
		dht_pkg::status_t st;
		logic [31:0]      value;
	} lookup_result_t;

	bit [9:0]  tag_mem [1024];
	bit [63:0] key_mem [1024];
	bit [3:0]  len_mem [1024];
	bit [31:0] val_mem [1024];
	int unsigned entries;
	int unsigned size_reg;
	lookup_result_t pending[$];
	int errors;
	int results;
	int status_seen [5];

	function new();
		foreach (tag_mem[i]) tag_mem[i] = '0;
		entries = 0;
		size_reg = dht_pkg::SIZE_RST;
		errors = 0;
		results = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
	endfunction

	function void set_size(bit [9:0] v);
		size_reg = v;
	endfunction

	// work out the answer for an accepted command and update the table
	function void note_command(bit [1:0] op, bit [63:0] raw, bit [3:0] len_in,
			bit [31:0] vin);
		lookup_result_t r;
		int unsigned sz, len, h, step, idx;
		bit [63:0] k;
		bit hit, free_slot;
		r.st = dht_pkg::ST_NOT_FOUND;
		r.value = '0;
		sz = size_reg;
		if (sz < 5) sz = 5;
		if (sz > 1021) sz = 1021;
		k = '0;
		hit = 0;
		free_slot = 0;
		if (op == dht_pkg::OP_CLEAR) begin
			foreach (tag_mem[i]) tag_mem[i] = '0;
			entries = 0;
			r.st = dht_pkg::ST_CLEARED;
		end else if (op != dht_pkg::OP_NONE) begin
			len = (len_in > 8) ? 8 : len_in;
			for (int i = 0; i < len; i++) k[8*i +: 8] = raw[8*i +: 8];
			h = len;
			for (int i = len; i > 0; i--) h = (h << 4) + k[8*(i-1) +: 8];
			h = h % sz;
			if (h == 0) h = 1;
			idx = h;
			if (tag_mem[idx] == 0) begin
				free_slot = 1;
			end else if (tag_mem[idx] == h && len_mem[idx] == len && key_mem[idx] == k) begin
				hit = 1;
			end else begin
				step = 1 + h % (sz - 2);
				forever begin
					if (idx <= step) idx = sz + idx - step;
					else idx = idx - step;
					if (idx == h) break;
					if (tag_mem[idx] == h && len_mem[idx] == len && key_mem[idx] == k) begin
						hit = 1;
						break;
					end
					if (tag_mem[idx] == 0) begin
						free_slot = 1;
						break;
					end
				end
			end
			if (hit) begin
				r.st = dht_pkg::ST_FOUND;
				r.value = val_mem[idx];
			end else if (op == dht_pkg::OP_ENTER) begin
				if (!free_slot || entries >= sz) begin
					r.st = dht_pkg::ST_FULL;
				end else begin
					tag_mem[idx] = h;
					key_mem[idx] = k;
					len_mem[idx] = len;
					val_mem[idx] = vin;
					entries++;
					r.st = dht_pkg::ST_INSERTED;
					r.value = vin;
				end
			end
		end
		pending.push_back(r);
	endfunction

	// compare one result beat with the oldest expectation
	function void check_result(bit [2:0] st, bit [31:0] v);
		lookup_result_t r;
		results++;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result beat status=%0d value=%h", $time, st, v);
			errors++;
			return;
		end
		r = pending.pop_front();
		status_seen[r.st]++;
		if (st != r.st) begin
			$display("%0t: status mismatch expected=%0d actual=%0d", $time, r.st, st);
			errors++;
		end
		if (v != r.value) begin
			$display("%0t: value_out mismatch expected=%h actual=%h", $time, r.value, v);
			errors++;
		end
	endfunction
endclass

module tb_double_hash_table_engine;
	import dht_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        table_size_we;
	logic [9:0]  table_size_wdata;
	logic        start;
	logic        busy;
	logic [1:0]  op;
	logic [63:0] key_bytes;
	logic [3:0]  key_len;
	logic signed [31:0] value_in;
	logic        done;
	logic [2:0]  status;
	logic signed [31:0] value_out;

	hash_table_scoreboard sb;
	int stall_cycles;
	int commands;
	bit [63:0] pool_key [32];
	bit [3:0]  pool_len [32];

	double_hash_table_engine i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.table_size_we(table_size_we),
		.table_size_wdata(table_size_wdata),
		.start(start),
		.busy(busy),
		.op(op),
		.key_bytes(key_bytes),
		.key_len(key_len),
		.value_in(value_in),
		.done(done),
		.status(status),
		.value_out(value_out)
	);

	initial clk = 0;
	always #2 clk = ~clk;

	// result beats and the stall watchdog
	always @(posedge clk) begin
		if (done) sb.check_result(status, value_out);
		if ((start && !busy) || done) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// drive one command beat after a random gap and wait for acceptance
	task automatic send_command(bit [1:0] o, bit [63:0] kb, bit [3:0] kl, bit [31:0] v);
		int gap;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start = 0;
			repeat (gap) @(negedge clk);
		end
		op = o;
		key_bytes = kb;
		key_len = kl;
		value_in = v;
		start = 1;
		do @(posedge clk); while (busy);
		sb.note_command(o, kb, kl, v);
		commands++;
		@(negedge clk);
	endtask

	// wait until every result has come, then write the size register
	task automatic write_size(bit [9:0] v);
		start = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		table_size_wdata = v;
		table_size_we = 1;
		@(negedge clk);
		table_size_we = 0;
		sb.set_size(v);
	endtask

	// random key: mostly from a small pool so lookups hit, bits above length random
	task automatic random_command();
		bit [63:0] kb;
		bit [3:0] kl;
		bit [1:0] o;
		int p, sel;
		sel = $urandom_range(0, 99);
		if (sel < 45) o = OP_FIND;
		else if (sel < 94) o = OP_ENTER;
		else if (sel < 97) o = OP_CLEAR;
		else o = OP_NONE;
		kb = {$urandom(), $urandom()};
		if ($urandom_range(0, 4) != 0) begin
			p = $urandom_range(0, 31);
			kl = pool_len[p];
			if (kl > 8 && $urandom_range(0, 1)) kl = 8;
			for (int i = 0; i < 8; i++) if (i < kl) kb[8*i +: 8] = pool_key[p][8*i +: 8];
		end else begin
			kl = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
		end
		send_command(o, kb, kl, $urandom());
	endtask

	task automatic refill_pool();
		foreach (pool_key[i]) begin
			pool_key[i] = {$urandom(), $urandom()};
			if ($urandom_range(0, 3) == 0) pool_key[i] = pool_key[i] & 64'h00FF_00FF_0000_FF00;
			pool_len[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
				: $urandom_range(0, 8);
		end
	endtask

	initial begin
		bit [9:0] sizes [11];
		sb = new();
		stall_cycles = 0;
		commands = 0;
		arst_n = 0;
		table_size_we = 0;
		table_size_wdata = '0;
		start = 0;
		op = OP_FIND;
		key_bytes = '0;
		key_len = '0;
		value_in = '0;
		repeat (3) @(negedge clk);
		arst_n = 1;
		// let the clearing pass after reset finish
		@(negedge clk);
		while (busy) @(negedge clk);

		// directed: clamp above range, empty key, extremes, duplicates, unused op, clear
		write_size(10'd1023);
		send_command(OP_FIND, 64'h0, 4'd0, 32'h0);
		send_command(OP_ENTER, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'h8000_0000);
		send_command(OP_FIND, 64'h1234, 4'd0, 32'h0);
		send_command(OP_ENTER, 64'h0, 4'd0, 32'h7FFF_FFFF);
		send_command(OP_ENTER, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF);
		send_command(OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'h0);
		send_command(OP_ENTER, 64'h0000_0000_0000_0000, 4'd3, 32'h1);
		send_command(OP_FIND, 64'hAB00_0000_0000_0000, 4'd3, 32'h0);
		send_command(OP_FIND, 64'h0, 4'd2, 32'h0);
		send_command(OP_NONE, 64'h0, 4'd3, 32'h5);
		send_command(OP_FIND, 64'h0, 4'd3, 32'h0);
		send_command(OP_CLEAR, 64'h0, 4'd0, 32'h0);
		send_command(OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
		// smallest table fills up, below-minimum size clamps to five
		write_size(10'd3);
		for (int i = 0; i < 7; i++) send_command(OP_ENTER, 64'(i * 37 + 1), 4'd1, i);
		send_command(OP_FIND, 64'd38, 4'd1, 32'h0);
		// non-prime size with entries kept from the last setting
		write_size(10'd9);
		send_command(OP_ENTER, 64'h55, 4'd2, 32'hA5A5_A5A5);
		send_command(OP_FIND, 64'd1, 4'd1, 32'h0);

		// random phases over several sizes, extremes included
		sizes = '{10'd5, 10'd7, 10'd1021, 10'd0, 10'd13, 10'd1020, 10'd9, 10'd31,
			10'd101, 10'd1023, 10'd11};
		foreach (sizes[s]) begin
			write_size(sizes[s]);
			refill_pool();
			for (int n = 0; n < 180; n++) random_command();
		end
		start = 0;

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		$display("ran %0d commands, %0d results over 14 table sizes", commands, sb.results);
		$display("found %0d, inserted %0d, not found %0d, full %0d, cleared %0d",
			sb.status_seen[ST_FOUND], sb.status_seen[ST_INSERTED],
			sb.status_seen[ST_NOT_FOUND], sb.status_seen[ST_FULL],
			sb.status_seen[ST_CLEARED]);
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
